FILE: hw/rtl/bba_pkg.sv
// shared types and codes for the block bitmap allocator
package bba_pkg;

	typedef enum logic [1:0] {
		OP_MARK_USED  = 2'd0,
		OP_MARK_FREE  = 2'd1,
		OP_FIND_FREE  = 2'd2,
		OP_COUNT_FREE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_NONE_FREE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MARK_DIV,
		S_MARK_RD,
		S_MARK_MOD,
		S_FIND,
		S_RESULT
	} state_t;

	localparam int IDX_W   = 10;
	localparam int COUNT_W = 11;

endpackage

FILE: hw/rtl/bba_ram.sv
// generic single-port-write ram with registered read
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/block_bitmap_allocator_unit.sv
// top level of the block bitmap allocator
//
// One used/free bit per storage block, held in a word-wide bitmap ram, plus a
// running count of free blocks. A request transaction on in_valid/in_ready
// carries opcode and block_index; every request gives exactly one result
// transaction on out_valid/out_ready with status, found_index and free_count.
// Requests are served one at a time.
// Steps from request accept to result valid:
//   count free: no bitmap access, straight to the result
//   mark used / mark free: word index, ram read, read-modify-write, result
//   find first free: one bitmap word per cycle
//   through the ram read port, stopping at the first word with a free block or at the last word
// With the defaults (1024 blocks, 32-bit words) a find reads at most 32 words.
// After reset the bitmap ram is cleared one word per cycle, all NUM_WORDS words
// (32 with the defaults), while in_ready stays low; the free count starts at
// NUM_BLOCKS. The result sits in an output register: a stalled receiver does
// not block accepting the next request, but that request's result waits until
// the previous one has been taken.
module block_bitmap_allocator_unit #(
	parameter int NUM_BLOCKS = 1024,
	parameter int WORD_BITS  = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  bba_pkg::opcode_t                 opcode,
	input  logic [bba_pkg::IDX_W-1:0]        block_index,
	output logic                             out_valid,
	input  logic                             out_ready,
	output bba_pkg::status_t                 status,
	output logic [bba_pkg::IDX_W-1:0]        found_index,
	output logic [bba_pkg::COUNT_W-1:0]      free_count
);

	import bba_pkg::*;

	localparam int NUM_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int BLK_W     = $clog2(NUM_BLOCKS);
	localparam int CW        = $clog2(NUM_BLOCKS + 1);
	localparam int LAST_BITS = NUM_BLOCKS - (NUM_WORDS - 1) * WORD_BITS;
	localparam logic [WORD_BITS-1:0] LAST_MASK =
		{WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
	localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);
	localparam int DIV_SHIFT = 17;
	localparam int DIV_MUL   = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
	localparam int PROD_W    = IDX_W + 15;
	localparam int QW        = PROD_W - DIV_SHIFT;

	state_t state_q, state_d;

	logic [AW-1:0]        clr_q;
	logic [CW-1:0]        free_total_q;
	logic                 out_valid_q;
	logic                 chk_v_q;
	logic [AW:0]          issue_q;
	logic [AW-1:0]        chk_word_q;

	opcode_t              op_q;
	logic [IDX_W-1:0]     idx_q;
	logic [QW-1:0]        quo_q;
	logic [BW-1:0]        bit_q;
	status_t              st_q;
	logic [AW-1:0]        found_word_q;
	logic [BW-1:0]        found_bit_q;
	status_t              status_q;
	logic [IDX_W-1:0]     found_index_q;
	logic [COUNT_W-1:0]   free_count_q;

	logic                 we;
	logic [AW-1:0]        waddr;
	logic [WORD_BITS-1:0] wdata;
	logic [AW-1:0]        raddr;
	logic [WORD_BITS-1:0] rdata;

	logic [PROD_W-1:0]    prod;
	logic                 out_of_range;
	logic [WORD_BITS-1:0] free_vec;
	logic                 any_free;
	logic [BW-1:0]        first_free;
	logic                 old_used;
	logic                 want_used;
	logic                 result_load;
	logic [BLK_W-1:0]     found_full;

	bba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NUM_WORDS)
	) u_bitmap (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign prod         = PROD_W'(idx_q) * PROD_W'(DIV_MUL);
	assign out_of_range = 17'(idx_q) >= 17'(NUM_BLOCKS);
	assign free_vec     = ~rdata & ((chk_word_q == LAST_WORD) ? LAST_MASK : {WORD_BITS{1'b1}});
	assign any_free     = |free_vec;
	assign old_used     = rdata[bit_q];
	assign want_used    = (op_q == OP_MARK_USED);
	assign found_full   = BLK_W'(found_word_q) * BLK_W'(WORD_BITS) + BLK_W'(found_bit_q);

	// lowest free bit of the checked word
	always_comb begin
		first_free = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				first_free = BW'(i);
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		we          = 1'b0;
		waddr       = clr_q;
		wdata       = '0;
		raddr       = chk_word_q;
		result_load = 1'b0;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				if (clr_q == LAST_WORD) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (opcode)
						OP_MARK_USED, OP_MARK_FREE: state_d = S_MARK_DIV;
						OP_FIND_FREE:               state_d = S_FIND;
						default:                    state_d = S_RESULT;
					endcase
				end
			end
			S_MARK_DIV: begin
				state_d = out_of_range ? S_RESULT : S_MARK_RD;
			end
			S_MARK_RD: begin
				raddr   = AW'(quo_q);
				state_d = S_MARK_MOD;
			end
			S_MARK_MOD: begin
				waddr   = AW'(quo_q);
				wdata   = rdata;
				wdata[bit_q] = want_used;
				we      = (old_used != want_used);
				state_d = S_RESULT;
			end
			S_FIND: begin
				raddr = issue_q[AW-1:0];
				if (chk_v_q && (any_free || chk_word_q == LAST_WORD)) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					result_load = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			free_total_q <= CW'(NUM_BLOCKS);
			out_valid_q  <= 1'b0;
			chk_v_q      <= 1'b0;
			issue_q      <= '0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_IDLE) begin
				chk_v_q <= 1'b0;
				issue_q <= '0;
			end
			if (state_q == S_FIND) begin
				chk_v_q <= 1'b1;
				issue_q <= issue_q + 1'b1;
			end
			if (state_q == S_MARK_MOD && old_used != want_used) begin
				free_total_q <= want_used ? free_total_q - 1'b1 : free_total_q + 1'b1;
			end
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q         <= opcode;
				idx_q        <= block_index;
				st_q         <= ST_OK;
				found_word_q <= '0;
				found_bit_q  <= '0;
			end
			S_MARK_DIV: begin
				quo_q <= prod[DIV_SHIFT +: QW];
				if (out_of_range) begin
					st_q <= ST_RANGE;
				end
			end
			S_MARK_RD: begin
				bit_q <= BW'(idx_q - IDX_W'(IDX_W'(quo_q) * IDX_W'(WORD_BITS)));
			end
			S_FIND: begin
				chk_word_q <= issue_q[AW-1:0];
				if (chk_v_q && any_free) begin
					found_word_q <= chk_word_q;
					found_bit_q  <= first_free;
				end else if (chk_v_q && chk_word_q == LAST_WORD) begin
					st_q <= ST_NONE_FREE;
				end
			end
			default: begin
			end
		endcase
		if (result_load) begin
			status_q      <= st_q;
			found_index_q <= IDX_W'(found_full);
			free_count_q  <= COUNT_W'(free_total_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_index_q;
	assign free_count  = free_count_q;

endmodule

FILE: bench/tb_top.sv
// self-checking testbench for the block bitmap allocator: directed and random requests
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bba_pkg::*;

	localparam int NUM_BLK     = 1024;
	localparam int HOLD_CYCLES = 300;
	localparam int WDOG_LIMIT  = 2000;
	localparam int RAND_ITEMS  = 550;

	typedef logic [IDX_W-1:0] blk_idx_t;
	typedef logic [COUNT_W-1:0] blk_cnt_t;

	typedef struct packed {
		status_t  st;
		blk_idx_t idx;
		blk_cnt_t cnt;
	} alloc_result_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	opcode_t  opcode;
	blk_idx_t block_index;
	logic     out_valid;
	logic     out_ready;
	status_t  status;
	blk_idx_t found_index;
	blk_cnt_t free_count;

	// allocator state as the bench sees it
	logic [NUM_BLK-1:0] used_map;
	int unsigned        free_left;
	status_t            last_status;
	blk_idx_t           last_found;

	alloc_result_t pending_results[$];

	int n_sent;
	int n_checked;
	int n_none_free;
	int n_errors;
	int hold_requests;
	int hold_served;
	int idle_cycles;

	block_bitmap_allocator_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.block_index (block_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.found_index (found_index),
		.free_count  (free_count)
	);

	always #6 clk = ~clk;

	function automatic alloc_result_t alloc_predict(input opcode_t op, input blk_idx_t idx);
		alloc_result_t r;
		logic          want_used;
		r.st  = ST_OK;
		r.idx = '0;
		case (op)
			OP_MARK_USED, OP_MARK_FREE: begin
				want_used = (op == OP_MARK_USED);
				if (int'(idx) >= NUM_BLK) begin
					r.st = ST_RANGE;
				end else if (used_map[idx] != want_used) begin
					used_map[idx] = want_used;
					if (want_used)
						free_left--;
					else
						free_left++;
				end
			end
			OP_FIND_FREE: begin
				r.st = ST_NONE_FREE;
				for (int i = 0; i < NUM_BLK; i++) begin
					if (!used_map[i]) begin
						r.st  = ST_OK;
						r.idx = blk_idx_t'(i);
						break;
					end
				end
				if (r.st == ST_NONE_FREE)
					n_none_free++;
			end
			default: ;
		endcase
		r.cnt       = blk_cnt_t'(free_left);
		last_status = r.st;
		last_found  = r.idx;
		return r;
	endfunction

	function automatic blk_idx_t rand_idx();
		return blk_idx_t'($urandom_range(0, NUM_BLK - 1));
	endfunction

	// prefer a block that is currently used
	function automatic blk_idx_t pick_used_block();
		blk_idx_t b;
		b = rand_idx();
		for (int t = 0; t < 16 && !used_map[b]; t++)
			b = rand_idx();
		return b;
	endfunction

	task automatic send_req(input opcode_t op, input blk_idx_t idx);
		int gap;
		gap = $urandom_range(0, 10);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		block_index <= idx;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(alloc_predict(op, idx));
		n_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_reset_state();
		send_req(OP_COUNT_FREE, '0);
		send_req(OP_FIND_FREE, '1);
		drain();
	endtask

	task automatic test_mark_basic();
		send_req(OP_MARK_USED, 10'd0);
		send_req(OP_MARK_USED, 10'd0);
		send_req(OP_FIND_FREE, 10'd0);
		send_req(OP_FIND_FREE, 10'd0);
		send_req(OP_MARK_USED, 10'd1);
		send_req(OP_FIND_FREE, '1);
		send_req(OP_MARK_USED, 10'd1023);
		send_req(OP_MARK_FREE, 10'd1023);
		send_req(OP_MARK_FREE, 10'd1023);
		send_req(OP_MARK_FREE, 10'd0);
		send_req(OP_FIND_FREE, 10'd0);
		send_req(OP_MARK_USED, 10'd31);
		send_req(OP_MARK_USED, 10'd32);
		send_req(OP_MARK_FREE, 10'd1);
		send_req(OP_MARK_FREE, 10'd31);
		send_req(OP_MARK_FREE, 10'd32);
		send_req(OP_COUNT_FREE, '1);
		drain();
	endtask

	task automatic test_fill_bitmap();
		for (int i = 0; i < NUM_BLK; i++)
			send_req(OP_MARK_USED, blk_idx_t'(i));
		send_req(OP_FIND_FREE, rand_idx());
		send_req(OP_COUNT_FREE, rand_idx());
		send_req(OP_MARK_USED, 10'd500);
		send_req(OP_MARK_FREE, 10'd777);
		send_req(OP_FIND_FREE, 10'd0);
		send_req(OP_MARK_USED, 10'd777);
		send_req(OP_FIND_FREE, '1);
		drain();
	endtask

	task automatic test_backpressure();
		hold_requests++;
		for (int i = 0; i < 12; i++)
			send_req(opcode_t'($urandom_range(0, 3)), rand_idx());
		drain();
	endtask

	task automatic test_random_mix();
		int start;
		int pick;
		start = n_sent;
		for (int i = 0; i < 24; i++)
			send_req(OP_MARK_FREE, pick_used_block());
		while (n_sent - start < RAND_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send_req(OP_FIND_FREE, rand_idx());
				if (last_status == ST_OK)
					send_req(OP_MARK_USED, last_found);
			end else if (pick < 70) begin
				send_req(OP_MARK_FREE, pick_used_block());
			end else if (pick < 80) begin
				send_req(OP_MARK_USED, rand_idx());
			end else if (pick < 88) begin
				send_req(OP_COUNT_FREE, rand_idx());
			end else if (pick < 96) begin
				send_req(OP_MARK_FREE, rand_idx());
			end else if (pick < 99) begin
				send_req(OP_FIND_FREE, rand_idx());
			end else begin
				drain();
			end
		end
		drain();
	endtask

	// receiver: random ready gaps, plus a long hold-off on request
	initial begin
		int gap;
		out_ready = 1'b0;
		forever begin
			gap = $urandom_range(0, 10);
			if (hold_requests != hold_served) begin
				gap = HOLD_CYCLES;
				hold_served++;
			end
			@(negedge clk);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// result checker
	always @(posedge clk) begin
		alloc_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			n_checked++;
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing expected: status %0d found %0d count %0d",
					status, found_index, free_count);
				n_errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.st) begin
					$error("status expected %0d got %0d", exp_r.st, status);
					n_errors++;
				end
				if (found_index !== exp_r.idx) begin
					$error("found_index expected %0d got %0d", exp_r.idx, found_index);
					n_errors++;
				end
				if (free_count !== exp_r.cnt) begin
					$error("free_count expected %0d got %0d", exp_r.cnt, free_count);
					n_errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
				idle_cycles, pending_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		opcode        = OP_MARK_USED;
		block_index   = '0;
		used_map      = '0;
		free_left     = NUM_BLK;
		last_status   = ST_OK;
		last_found    = '0;
		n_sent        = 0;
		n_checked     = 0;
		n_none_free   = 0;
		n_errors      = 0;
		hold_requests = 0;
		hold_served   = 0;
		idle_cycles   = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_mark_basic();
		test_fill_bitmap();
		test_backpressure();
		test_random_mix();

		repeat (40) @(posedge clk);
		$display("covered %0d requests (%0d results checked), full-bitmap fill,", n_sent,
			n_checked);
		$display("%0d finds with no free block, long output hold-off and drain pauses",
			n_none_free);
		if (n_errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
